@@ src/slot_alloc_pkg.sv @@
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared types and defaults for the slot allocator cells, stack and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package slot_alloc_pkg;

    localparam int SLOT_CAPACITY_DEF = 1024;
    localparam int KEY_WIDTH_DEF     = 32;

    // fixed port widths
    localparam int IDX_W   = 11;
    localparam int KEY_W   = 32;
    localparam int RSLOT_W = 10;
    localparam int COUNT_W = 11;

    typedef enum logic [2:0] {
        CMD_ALLOC     = 3'd0,
        CMD_BIND      = 3'd1,
        CMD_ALLOC_KEY = 3'd2,
        CMD_REL_SLOT  = 3'd3,
        CMD_REL_KEY   = 3'd4,
        CMD_LOOKUP    = 3'd5,
        CMD_READ      = 3'd6,
        CMD_COUNT     = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } state_t;

    // broadcast update applied by every cell
    typedef struct packed {
        logic wr_en;
        logic key_we;
        logic mapped_we;
        logic mapped_val;
        logic infree_we;
        logic infree_val;
        logic unmap_a_en;
        logic unmap_b_en;
    } cell_ctl_t;

    // flags carried along the chain
    typedef struct packed {
        logic hit;
        logic hit_infree;
        logic idx_infree;
    } scan_flags_t;

endpackage

`default_nettype wire

@@ src/slot_alloc_cell.sv @@
// ----------------------------------------------------------------------------
// Slot allocator cell
// Holds one slot (key, mapped, in-free-stack) and passes scan results along.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_alloc_cell #(
    parameter int KW       = slot_alloc_pkg::KEY_WIDTH_DEF,
    parameter int SW       = 10,
    parameter int CELL_IDX = 0
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire slot_alloc_pkg::cell_ctl_t   ctl,
    input  wire logic [SW-1:0]               wr_idx,
    input  wire logic [KW-1:0]               wr_key,
    input  wire logic [KW-1:0]               unmap_a,
    input  wire logic [KW-1:0]               unmap_b,
    input  wire logic [KW-1:0]               q_key,
    input  wire logic [slot_alloc_pkg::IDX_W-1:0] q_idx,
    input  wire slot_alloc_pkg::scan_flags_t in_flags,
    input  wire logic [SW-1:0]               in_hit_idx,
    input  wire logic [KW-1:0]               in_idx_key,
    output slot_alloc_pkg::scan_flags_t      out_flags,
    output logic [SW-1:0]                    out_hit_idx,
    output logic [KW-1:0]                    out_idx_key
);

    localparam logic [SW-1:0] MY_SLOT = SW'(CELL_IDX);
    localparam logic [31:0]   MY_IDX  = 32'(CELL_IDX);

    logic [KW-1:0] key_reg, key_next;
    logic          mapped_reg, mapped_next;
    logic          infree_reg, infree_next;
    logic          wr_sel, q_sel, key_hit;

    slot_alloc_pkg::scan_flags_t flags_reg, flags_next;
    logic [SW-1:0] hit_idx_reg, hit_idx_next;
    logic [KW-1:0] idx_key_reg, idx_key_next;

    assign wr_sel  = ctl.wr_en && (wr_idx == MY_SLOT);
    assign q_sel   = (32'(q_idx) == MY_IDX);
    assign key_hit = mapped_reg && (key_reg == q_key);

    // local update: unmap by key first, addressed write wins
    always_comb begin
        key_next    = key_reg;
        mapped_next = mapped_reg;
        infree_next = infree_reg;
        if (ctl.unmap_a_en && key_reg == unmap_a) begin
            mapped_next = 1'b0;
        end
        if (ctl.unmap_b_en && key_reg == unmap_b) begin
            mapped_next = 1'b0;
        end
        if (wr_sel) begin
            if (ctl.key_we)    key_next    = wr_key;
            if (ctl.mapped_we) mapped_next = ctl.mapped_val;
            if (ctl.infree_we) infree_next = ctl.infree_val;
        end
    end

    // scan stage: first mapped match wins, addressed slot reports itself
    always_comb begin
        flags_next   = in_flags;
        hit_idx_next = in_hit_idx;
        idx_key_next = in_idx_key;
        if (!in_flags.hit && key_hit) begin
            flags_next.hit        = 1'b1;
            flags_next.hit_infree = infree_reg;
            hit_idx_next          = MY_SLOT;
        end
        if (q_sel) begin
            flags_next.idx_infree = infree_reg;
            idx_key_next          = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mapped_reg <= 1'b0;
            infree_reg <= 1'b0;
        end else begin
            mapped_reg <= mapped_next;
            infree_reg <= infree_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        flags_reg   <= flags_next;
        hit_idx_reg <= hit_idx_next;
        idx_key_reg <= idx_key_next;
    end

    assign out_flags   = flags_reg;
    assign out_hit_idx = hit_idx_reg;
    assign out_idx_key = idx_key_reg;

endmodule

`default_nettype wire

@@ src/slot_alloc_stack.sv @@
// ----------------------------------------------------------------------------
// Slot allocator free stack
// Single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_alloc_stack #(
    parameter int DEPTH = slot_alloc_pkg::SLOT_CAPACITY_DEF,
    parameter int SW    = 10
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [SW-1:0] wr_addr,
    input  wire logic [SW-1:0] wr_data,
    input  wire logic [SW-1:0] rd_addr,
    output logic [SW-1:0]      rd_data
);

    logic [SW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ src/slot_alloc_chain.sv @@
// ----------------------------------------------------------------------------
// Slot allocator cell chain
// One cell per slot; scan results ripple one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_alloc_chain #(
    parameter int CAP = slot_alloc_pkg::SLOT_CAPACITY_DEF,
    parameter int KW  = slot_alloc_pkg::KEY_WIDTH_DEF,
    parameter int SW  = 10
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire slot_alloc_pkg::cell_ctl_t   ctl,
    input  wire logic [SW-1:0]               wr_idx,
    input  wire logic [KW-1:0]               wr_key,
    input  wire logic [KW-1:0]               unmap_a,
    input  wire logic [KW-1:0]               unmap_b,
    input  wire logic [KW-1:0]               q_key,
    input  wire logic [slot_alloc_pkg::IDX_W-1:0] q_idx,
    output slot_alloc_pkg::scan_flags_t      res_flags,
    output logic [SW-1:0]                    res_hit_idx,
    output logic [KW-1:0]                    res_idx_key
);

    slot_alloc_pkg::scan_flags_t link_flags [CAP+1];
    logic [SW-1:0]               link_hit   [CAP+1];
    logic [KW-1:0]               link_key   [CAP+1];

    // chain head: nothing found yet
    assign link_flags[0] = '0;
    assign link_hit[0]   = '0;
    assign link_key[0]   = '0;

    for (genvar i = 0; i < CAP; i++) begin : g_cell
        slot_alloc_cell #(
            .KW       (KW),
            .SW       (SW),
            .CELL_IDX (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .wr_idx      (wr_idx),
            .wr_key      (wr_key),
            .unmap_a     (unmap_a),
            .unmap_b     (unmap_b),
            .q_key       (q_key),
            .q_idx       (q_idx),
            .in_flags    (link_flags[i]),
            .in_hit_idx  (link_hit[i]),
            .in_idx_key  (link_key[i]),
            .out_flags   (link_flags[i+1]),
            .out_hit_idx (link_hit[i+1]),
            .out_idx_key (link_key[i+1])
        );
    end

    assign res_flags   = link_flags[CAP];
    assign res_hit_idx = link_hit[CAP];
    assign res_idx_key = link_key[CAP];

endmodule

`default_nettype wire

@@ src/slot_alloc_with_reverse_map_core.sv @@
// Each command makes a scan pass through the cell chain, then an update step, then
//   returns to idle; the update waits while an earlier result beat waits on m_ready.
// A new command is accepted only in idle, after the previous command's update step.
// Reset: synchronous, active low; table and free stack come up empty with no
//   clearing pass.
// ----------------------------------------------------------------------------
// Slot allocator with reverse map - top level
// Sequencer, free stack and slot cell chain for the eight table commands.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_allocator_with_reverse_map_core #(
    parameter int SLOT_CAPACITY = slot_alloc_pkg::SLOT_CAPACITY_DEF,
    parameter int KEY_WIDTH     = slot_alloc_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [2:0]                          s_command,
    input  wire logic [slot_alloc_pkg::IDX_W-1:0]    s_slot_index,
    input  wire logic [slot_alloc_pkg::KEY_W-1:0]    s_object_key,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [slot_alloc_pkg::RSLOT_W-1:0]       m_result_slot,
    output logic [slot_alloc_pkg::KEY_W-1:0]         m_result_key,
    output logic                                     m_ok,
    output logic [slot_alloc_pkg::COUNT_W-1:0]       m_slot_count
);

    localparam int SW    = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
    localparam int CNT_W = $clog2(SLOT_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(SLOT_CAPACITY);

    slot_alloc_pkg::state_t state_reg, state_next;
    slot_alloc_pkg::cmd_t   cmd_reg;
    logic [slot_alloc_pkg::IDX_W-1:0] idx_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [CNT_W-1:0]       depth_reg, depth_next;

    logic                   m_valid_reg, m_valid_next;
    logic [slot_alloc_pkg::RSLOT_W-1:0] rslot_reg, rslot_next;
    logic [slot_alloc_pkg::KEY_W-1:0]   rkey_reg, rkey_next;
    logic                   ok_reg, ok_next;

    slot_alloc_pkg::cell_ctl_t   ctl;
    logic [SW-1:0]               wr_idx;
    logic [KEY_WIDTH-1:0]        wr_key, unmap_a, unmap_b;
    slot_alloc_pkg::scan_flags_t res_flags;
    logic [SW-1:0]               res_hit_idx;
    logic [KEY_WIDTH-1:0]        res_idx_key;

    logic          stk_we;
    logic [SW-1:0] stk_wr_addr, stk_wr_data, stk_rd_addr, stk_rd;

    logic          accept, out_free;
    logic          key_nz, idx_ok, pop_ok, grow_ok, take_ok;
    logic [SW-1:0] take_slot, idx_slot;
    logic          rel_go;
    logic [SW-1:0] rel_slot;
    logic [KEY_WIDTH-1:0] rel_key;
    logic          rel_infree;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == slot_alloc_pkg::ST_IDLE);

    // top of free stack, read ahead during the scan
    assign stk_rd_addr = SW'(depth_reg - CNT_W'(1));

    slot_alloc_stack #(
        .DEPTH (SLOT_CAPACITY),
        .SW    (SW)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (stk_we),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd)
    );

    slot_alloc_chain #(
        .CAP (SLOT_CAPACITY),
        .KW  (KEY_WIDTH),
        .SW  (SW)
    ) u_chain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .wr_idx      (wr_idx),
        .wr_key      (wr_key),
        .unmap_a     (unmap_a),
        .unmap_b     (unmap_b),
        .q_key       (key_reg),
        .q_idx       (idx_reg),
        .res_flags   (res_flags),
        .res_hit_idx (res_hit_idx),
        .res_idx_key (res_idx_key)
    );

    // operand checks
    assign key_nz    = (key_reg != '0);
    assign idx_ok    = (32'(idx_reg) < 32'(used_reg));
    assign idx_slot  = SW'(idx_reg);
    assign pop_ok    = (depth_reg != '0) && (32'(stk_rd) < 32'(used_reg));
    assign grow_ok   = (used_reg != CAP_CNT);
    assign take_ok   = pop_ok || grow_ok;
    assign take_slot = pop_ok ? stk_rd : SW'(used_reg);

    // sequencer and command execution
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        used_next    = used_reg;
        depth_next   = depth_reg;
        m_valid_next = m_valid_reg;
        rslot_next   = rslot_reg;
        rkey_next    = rkey_reg;
        ok_next      = ok_reg;
        ctl          = '0;
        wr_idx       = '0;
        wr_key       = '0;
        unmap_a      = '0;
        unmap_b      = '0;
        stk_we       = 1'b0;
        stk_wr_addr  = SW'(depth_reg);
        stk_wr_data  = '0;
        rel_go       = 1'b0;
        rel_slot     = '0;
        rel_key      = '0;
        rel_infree   = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            slot_alloc_pkg::ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    state_next = slot_alloc_pkg::ST_SCAN;
                end
            end
            slot_alloc_pkg::ST_SCAN: begin
                if (cnt_reg == CAP_CNT) begin
                    if (out_free) begin
                        state_next = slot_alloc_pkg::ST_EXEC;
                    end
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            slot_alloc_pkg::ST_EXEC: begin
                state_next   = slot_alloc_pkg::ST_IDLE;
                m_valid_next = 1'b1;
                rslot_next   = '0;
                rkey_next    = '0;
                ok_next      = 1'b0;
                unique case (cmd_reg)
                    slot_alloc_pkg::CMD_ALLOC,
                    slot_alloc_pkg::CMD_ALLOC_KEY: begin
                        if (cmd_reg == slot_alloc_pkg::CMD_ALLOC_KEY && !key_nz) begin
                            ok_next = 1'b0;
                        end else if (cmd_reg == slot_alloc_pkg::CMD_ALLOC_KEY &&
                                     res_flags.hit) begin
                            rslot_next = slot_alloc_pkg::RSLOT_W'(res_hit_idx);
                            ok_next    = 1'b1;
                        end else begin
                            if (depth_reg != '0) begin
                                depth_next = depth_reg - CNT_W'(1);
                            end
                            if (!pop_ok && grow_ok) begin
                                used_next = used_reg + CNT_W'(1);
                            end
                            if (take_ok) begin
                                ctl.wr_en      = 1'b1;
                                ctl.key_we     = 1'b1;
                                ctl.mapped_we  = 1'b1;
                                ctl.infree_we  = 1'b1;
                                ctl.infree_val = 1'b0;
                                wr_idx         = take_slot;
                                if (cmd_reg == slot_alloc_pkg::CMD_ALLOC_KEY) begin
                                    wr_key         = key_reg;
                                    ctl.mapped_val = 1'b1;
                                end
                                rslot_next = slot_alloc_pkg::RSLOT_W'(take_slot);
                                ok_next    = 1'b1;
                            end
                        end
                    end
                    slot_alloc_pkg::CMD_BIND: begin
                        if (key_nz && idx_ok) begin
                            ctl.unmap_a_en = (res_idx_key != '0) && (res_idx_key != key_reg);
                            unmap_a        = res_idx_key;
                            ctl.unmap_b_en = 1'b1;
                            unmap_b        = key_reg;
                            ctl.wr_en      = 1'b1;
                            ctl.key_we     = 1'b1;
                            ctl.mapped_we  = 1'b1;
                            ctl.mapped_val = 1'b1;
                            wr_idx         = idx_slot;
                            wr_key         = key_reg;
                            ok_next        = 1'b1;
                        end
                    end
                    slot_alloc_pkg::CMD_REL_SLOT: begin
                        if (idx_ok) begin
                            rel_go     = 1'b1;
                            rel_slot   = idx_slot;
                            rel_key    = res_idx_key;
                            rel_infree = res_flags.idx_infree;
                            ok_next    = 1'b1;
                        end
                    end
                    slot_alloc_pkg::CMD_REL_KEY: begin
                        if (key_nz && res_flags.hit) begin
                            rel_go     = 1'b1;
                            rel_slot   = res_hit_idx;
                            rel_key    = key_reg;
                            rel_infree = res_flags.hit_infree;
                            ok_next    = 1'b1;
                        end
                    end
                    slot_alloc_pkg::CMD_LOOKUP: begin
                        if (key_nz && res_flags.hit) begin
                            rslot_next = slot_alloc_pkg::RSLOT_W'(res_hit_idx);
                            ok_next    = 1'b1;
                        end
                    end
                    slot_alloc_pkg::CMD_READ: begin
                        if (idx_ok) begin
                            rkey_next = slot_alloc_pkg::KEY_W'(res_idx_key);
                            ok_next   = 1'b1;
                        end
                    end
                    slot_alloc_pkg::CMD_COUNT: begin
                        ok_next = 1'b1;
                    end
                    default: begin
                        ok_next = 1'b1;
                    end
                endcase

                // release: empty the slot, drop its key's mapping, push once
                if (rel_go) begin
                    wr_idx    = rel_slot;
                    ctl.wr_en = 1'b1;
                    if (rel_key != '0) begin
                        ctl.unmap_a_en = 1'b1;
                        unmap_a        = rel_key;
                        ctl.key_we     = 1'b1;
                        wr_key         = '0;
                    end
                    if (!rel_infree && depth_reg != CAP_CNT) begin
                        stk_we         = 1'b1;
                        stk_wr_data    = rel_slot;
                        depth_next     = depth_reg + CNT_W'(1);
                        ctl.infree_we  = 1'b1;
                        ctl.infree_val = 1'b1;
                    end
                end
            end
            default: begin
                state_next = slot_alloc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= slot_alloc_pkg::ST_IDLE;
            cnt_reg     <= '0;
            used_reg    <= '0;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            used_reg    <= used_next;
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // operand and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= slot_alloc_pkg::cmd_t'(s_command);
            idx_reg <= s_slot_index;
            key_reg <= KEY_WIDTH'(s_object_key);
        end
        rslot_reg <= rslot_next;
        rkey_reg  <= rkey_next;
        ok_reg    <= ok_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_result_slot = rslot_reg;
    assign m_result_key  = rkey_reg;
    assign m_ok          = ok_reg;
    assign m_slot_count  = slot_alloc_pkg::COUNT_W'(used_reg);

endmodule

`default_nettype wire
